// ----- design/mchw_pkg.sv -----
package mchw_pkg;

  // Number of supervised channels and the width of a channel index.
  localparam int CHANNELS = 8;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [2:0] req_type_t;
  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  // Request kinds.
  localparam req_type_t REQ_TICK      = 3'd0;
  localparam req_type_t REQ_HEARTBEAT = 3'd1;
  localparam req_type_t REQ_AUDIT     = 3'd2;
  localparam req_type_t REQ_ARM       = 3'd3;
  localparam req_type_t REQ_EXIT      = 3'd4;
  localparam req_type_t REQ_SHUTDOWN  = 3'd5;

  // Result actions.
  localparam action_t ACT_WARN    = 2'd0;
  localparam action_t ACT_KILL    = 2'd1;
  localparam action_t ACT_RESPAWN = 2'd2;
  localparam action_t ACT_DONE    = 2'd3;

  // Channel states.
  localparam status_t ST_DEAD    = 2'd0;
  localparam status_t ST_ALIVE   = 2'd1;
  localparam status_t ST_RESTART = 2'd2;

endpackage

// ----- design/mchw_req_if.sv -----
interface mchw_req_if;
  logic                  valid;
  logic                  ready;
  mchw_pkg::req_type_t   req_type;
  logic [3:0]            channel;
  logic [15:0]           response_ms;
  logic [15:0]           critical_ms;
  logic                  start_ok;

  modport source (output valid, req_type, channel, response_ms, critical_ms, start_ok,
                  input ready);
  modport sink (input valid, req_type, channel, response_ms, critical_ms, start_ok,
                output ready);
endinterface

// ----- design/mchw_res_if.sv -----
interface mchw_res_if;
  logic                valid;
  logic                ready;
  mchw_pkg::action_t   action;
  logic [3:0]          channel_res;
  logic                last;

  modport source (output valid, action, channel_res, last, input ready);
  modport sink (input valid, action, channel_res, last, output ready);
endinterface

// ----- design/multi_channel_heartbeat_watchdog.sv -----
// Tick, heartbeat, arm and exit beats produce no result.
// Audit and shutdown accept the request, visit each channel in turn in the shared
// elapsed-time subtract and compare unit, then issue the done beat; a stalled result
// beat holds the walk at a channel that has a result to emit.
// Synchronous active-high reset clears the millisecond counter, marks every
// channel dead and unarmed and empties the result register.
module multi_channel_heartbeat_watchdog (
  input  logic        clk,
  input  logic        rst,
  mchw_req_if.sink    req,
  mchw_res_if.source  res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                      state;
  logic                            shutdown_mode;
  logic [mchw_pkg::CH_W-1:0]       idx;
  logic [31:0]                     now_ms;

  mchw_pkg::status_t               channel_status [mchw_pkg::CHANNELS];
  logic                            channel_armed  [mchw_pkg::CHANNELS];
  logic [31:0]                     last_seen_ms   [mchw_pkg::CHANNELS];
  logic [15:0]                     response_limit [mchw_pkg::CHANNELS];
  logic [15:0]                     critical_limit [mchw_pkg::CHANNELS];

  logic                            out_valid;
  mchw_pkg::action_t               out_action;
  logic [3:0]                      out_channel;
  logic                            out_last;

  logic                            accept;
  logic                            ch_ok;
  logic [mchw_pkg::CH_W-1:0]       ch_idx;
  logic                            out_free;

  logic [31:0]                     elapsed;
  logic                            within_resp;
  logic                            below_crit;
  logic                            walk_emit;
  mchw_pkg::action_t               walk_action;
  mchw_pkg::status_t               walk_status;
  logic                            walk_touch;
  logic                            walk_step;
  logic                            walk_end;

  logic                            load;
  mchw_pkg::action_t               load_action;
  logic [3:0]                      load_channel;
  logic                            load_last;

  // Handshake and address decode.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign ch_ok     = ({1'b0, req.channel} < 5'(mchw_pkg::CHANNELS));
  assign ch_idx    = req.channel[mchw_pkg::CH_W-1:0];
  assign out_free  = !out_valid || res.ready;

  // Shared unit: elapsed time and limit compares for the channel being visited.
  assign elapsed     = now_ms - last_seen_ms[idx];
  assign within_resp = (elapsed <= {16'b0, response_limit[idx]});
  assign below_crit  = (elapsed <  {16'b0, critical_limit[idx]});

  // Decision for the visited channel.
  always_comb begin
    walk_emit   = 1'b0;
    walk_action = mchw_pkg::ACT_KILL;
    walk_status = channel_status[idx];
    walk_touch  = 1'b0;
    if (shutdown_mode) begin
      if (channel_armed[idx] && (channel_status[idx] != mchw_pkg::ST_DEAD)) begin
        walk_emit   = 1'b1;
        walk_status = mchw_pkg::ST_DEAD;
      end
    end else begin
      unique case (channel_status[idx])
        mchw_pkg::ST_RESTART: begin
          walk_emit   = 1'b1;
          walk_action = mchw_pkg::ACT_RESPAWN;
          walk_status = mchw_pkg::ST_ALIVE;
          walk_touch  = 1'b1;
        end
        mchw_pkg::ST_ALIVE: begin
          if (!within_resp) begin
            walk_emit = 1'b1;
            if (below_crit) begin
              walk_action = mchw_pkg::ACT_WARN;
            end else begin
              walk_status = mchw_pkg::ST_DEAD;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign walk_step = (state == S_WALK) && (!walk_emit || out_free);
  assign walk_end  = (idx == mchw_pkg::CH_W'(mchw_pkg::CHANNELS - 1));

  // Result register load selection.
  always_comb begin
    load         = 1'b0;
    load_action  = mchw_pkg::ACT_DONE;
    load_channel = 4'd0;
    load_last    = 1'b1;
    if (walk_step && walk_emit) begin
      load         = 1'b1;
      load_action  = walk_action;
      load_channel = 4'(idx);
      load_last    = 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      load = 1'b1;
    end
  end

  // Sequencer, control state and status stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      shutdown_mode <= 1'b0;
      idx           <= '0;
      now_ms        <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < mchw_pkg::CHANNELS; i++) begin
        channel_status[i] <= mchw_pkg::ST_DEAD;
        channel_armed[i]  <= 1'b0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.req_type)
              mchw_pkg::REQ_TICK: now_ms <= now_ms + 32'd1;
              mchw_pkg::REQ_AUDIT: begin
                state         <= S_WALK;
                shutdown_mode <= 1'b0;
                idx           <= '0;
              end
              mchw_pkg::REQ_SHUTDOWN: begin
                state         <= S_WALK;
                shutdown_mode <= 1'b1;
                idx           <= '0;
              end
              mchw_pkg::REQ_ARM: begin
                if (ch_ok) begin
                  channel_armed[ch_idx]  <= 1'b1;
                  channel_status[ch_idx] <= req.start_ok ? mchw_pkg::ST_ALIVE
                                                         : mchw_pkg::ST_DEAD;
                end
              end
              mchw_pkg::REQ_EXIT: begin
                if (ch_ok && channel_armed[ch_idx] &&
                    (channel_status[ch_idx] == mchw_pkg::ST_DEAD)) begin
                  channel_status[ch_idx] <= mchw_pkg::ST_RESTART;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_WALK: begin
          if (walk_step) begin
            channel_status[idx] <= walk_status;
            if (walk_end) begin
              state <= S_DONE;
            end else begin
              idx <= idx + mchw_pkg::CH_W'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Timestamp and limit stores and the result payload.
  always_ff @(posedge clk) begin
    if (accept && ch_ok) begin
      if ((req.req_type == mchw_pkg::REQ_HEARTBEAT) ||
          (req.req_type == mchw_pkg::REQ_ARM)) begin
        last_seen_ms[ch_idx] <= now_ms;
      end
      if (req.req_type == mchw_pkg::REQ_ARM) begin
        response_limit[ch_idx] <= req.response_ms;
        critical_limit[ch_idx] <= req.critical_ms;
      end
    end
    if (walk_step && walk_touch) begin
      last_seen_ms[idx] <= now_ms;
    end
    if (load) begin
      out_action  <= load_action;
      out_channel <= load_channel;
      out_last    <= load_last;
    end
  end

  assign res.valid       = out_valid;
  assign res.action      = out_action;
  assign res.channel_res = out_channel;
  assign res.last        = out_last;

endmodule

// ----- design/mchw_chk.sv -----
module mchw_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input mchw_pkg::req_type_t in_req_type,
  input logic                out_valid,
  input logic                out_ready,
  input mchw_pkg::action_t   out_action,
  input logic [3:0]          out_channel_res,
  input logic                out_last
);

  // Reset leaves no result beat pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat pending after reset");

  // A walk request closes the input until the walk is over.
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready &&
     (in_req_type == mchw_pkg::REQ_AUDIT || in_req_type == mchw_pkg::REQ_SHUTDOWN))
    |=> !in_ready)
    else $error("input ready right after an audit or shutdown beat");

  // The final beat is always a done on channel zero, and only it is a done.
  a_done_form: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_action == mchw_pkg::ACT_DONE)) &&
                  (!out_last || out_channel_res == 4'd0))
    else $error("malformed done beat");

  // A pending per-channel result means a walk is still under way.
  a_mid_walk: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input ready while a walk result is pending");

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      out_valid && $stable(out_action) && $stable(out_channel_res) && $stable(out_last))
    else $error("stalled result beat changed");

endmodule

bind multi_channel_heartbeat_watchdog mchw_chk u_mchw_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (req.valid),
  .in_ready        (req.ready),
  .in_req_type     (req.req_type),
  .out_valid       (res.valid),
  .out_ready       (res.ready),
  .out_action      (res.action),
  .out_channel_res (res.channel_res),
  .out_last        (res.last)
);
